FILE: rtl/hptm_pkg.sv
// Shared constants for the HDR pixel tone mapper.
package hptm_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_TONE_MODE     = 8'd0;
  localparam logic [7:0] CFG_EXPOSURE_GAIN = 8'd1;

  // Fixed-point constants (Q16.16 / Q0.16)
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [32:0] RATIO_C_Q16 = 33'd19661;
  localparam logic [14:0] GAMMA_B_Q16 = 15'd29789;
  // POW_MAGIC * (65536 - GAMMA_B)
  localparam logic [46:0] POW_OFFSET  = 47'd38081544235499;

  // Divider stage count
  localparam int DIV_STAGES = 8;
  // Cycles from a taken request to its result strobe
  localparam int CH_LATENCY = DIV_STAGES + 5;

endpackage

FILE: rtl/hptm_channel.sv
// One colour channel of the tone mapper: float decode, divide or power curve, gain.
module hptm_channel (
  input  logic        clk,
  input  logic [30:0] bits_i,
  input  logic        mode_i,
  input  logic [16:0] gain_i,
  output logic [7:0]  val_o
);
  import hptm_pkg::*;

  // Float pattern to Q16.16, truncating, saturating at 65536.0
  function automatic logic [31:0] to_q16(input logic [30:0] b);
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [31:0] sig;
    e   = b[30:23];
    sig = {8'd0, 1'b1, b[22:0]};
    sh  = 8'd0;
    if (e == 8'd0) begin
      to_q16 = 32'd0;
    end else if (e == 8'd255) begin
      to_q16 = 32'hFFFF_FFFF;
    end else if (e >= 8'd134) begin
      sh = e - 8'd134;
      if (sh > 8'd8) to_q16 = 32'hFFFF_FFFF;
      else           to_q16 = sig << sh[3:0];
    end else begin
      sh = 8'd134 - e;
      if (sh >= 8'd24) to_q16 = 32'd0;
      else             to_q16 = sig >> sh[4:0];
    end
  endfunction

  // Power-curve pattern to display value, with the clamp at 1.0
  function automatic logic [7:0] pat_to_v(input logic [30:0] p);
    logic [31:0] t;
    logic [24:0] prod;
    t = to_q16(p);
    prod = 25'd0;
    if (p[30:23] >= 8'd127) begin
      pat_to_v = 8'd255;
    end else begin
      prod = ({t[16:0], 8'd0} - {8'd0, t[16:0]});
      pat_to_v = prod[23:16];
    end
  endfunction

  // Stage 1: capture inputs
  logic [30:0] bits_r;
  logic        md0_r;
  always_ff @(posedge clk) begin
    bits_r <= bits_i;
    md0_r  <= mode_i;
  end

  // Stage 2: decode to fixed point, form divisor and power product
  logic [31:0] x1_r;
  logic [32:0] d1_r;
  logic [45:0] prod1_r;
  logic        md1_r;
  logic [31:0] x1_nxt;
  always_comb x1_nxt = to_q16(bits_r);
  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    d1_r    <= {1'b0, x1_nxt} + RATIO_C_Q16;
    prod1_r <= 46'(bits_r) * 46'(GAMMA_B_Q16);
    md1_r   <= md0_r;
  end

  // Stage 3: new bit pattern for the power curve, seed the divider
  logic [30:0] pat2_r;
  logic [32:0] rem2_r;
  logic [32:0] d2_r;
  logic        md2_r;
  logic [46:0] num2;
  always_comb num2 = POW_OFFSET + 47'(prod1_r);
  always_ff @(posedge clk) begin
    pat2_r <= num2[46:16];
    rem2_r <= {1'b0, x1_r};
    d2_r   <= d1_r;
    md2_r  <= md1_r;
  end

  // Divider stages: two restoring steps each
  logic [32:0] rem_r [DIV_STAGES];
  logic [32:0] dd_r  [DIV_STAGES];
  logic [15:0] q_r   [DIV_STAGES];
  logic [7:0]  v1_r  [DIV_STAGES];
  logic        md_r  [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [32:0] rin, din, ra, rb;
      logic [33:0] s0, s1;
      logic [15:0] qin;
      logic [7:0]  vin;
      logic        min_;
      logic        b0, b1;
      if (k == 0) begin : g_first
        assign rin  = rem2_r;
        assign din  = d2_r;
        assign qin  = 16'd0;
        assign vin  = pat_to_v(pat2_r);
        assign min_ = md2_r;
      end else begin : g_next
        assign rin  = rem_r[k-1];
        assign din  = dd_r[k-1];
        assign qin  = q_r[k-1];
        assign vin  = v1_r[k-1];
        assign min_ = md_r[k-1];
      end
      always_comb begin
        s0 = {rin, 1'b0};
        b0 = (s0 >= {1'b0, din});
        ra = b0 ? 33'(s0 - {1'b0, din}) : s0[32:0];
        s1 = {ra, 1'b0};
        b1 = (s1 >= {1'b0, din});
        rb = b1 ? 33'(s1 - {1'b0, din}) : s1[32:0];
      end
      always_ff @(posedge clk) begin
        rem_r[k] <= rb;
        dd_r[k]  <= din;
        q_r[k]   <= {qin[13:0], b0, b1};
        v1_r[k]  <= vin;
        md_r[k]  <= min_;
      end
    end
  endgenerate

  // Scale quotient by 255 and pick the curve
  logic [7:0]  v_r;
  logic [23:0] q255;
  always_comb q255 = {q_r[DIV_STAGES-1], 8'd0} - {8'd0, q_r[DIV_STAGES-1]};
  always_ff @(posedge clk) begin
    v_r <= md_r[DIV_STAGES-1] ? v1_r[DIV_STAGES-1] : q255[23:16];
  end

  // Apply exposure gain
  logic [24:0] g_prod;
  logic [7:0]  out_r;
  always_comb g_prod = 25'(v_r) * 25'(gain_i);
  always_ff @(posedge clk) begin
    out_r <= g_prod[23:16];
  end
  assign val_o = out_r;

endmodule

FILE: rtl/hdr_pixel_tone_mapper_top.sv
// Top level of the HDR pixel tone mapper.
// One pixel request is taken per clock while rst_n is high (busy is only high in
// reset); its result strobes on out_valid after decode, the eight-stage restoring
// divider of the rational curve, and the curve and gain stages. The receiver
// cannot stall, so results are never held. Configuration writes are always
// taken and should be made with no pixel in flight.
module hdr_pixel_tone_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] in_red_in,
  input  logic [30:0] in_green_in,
  input  logic [30:0] in_blue_in,
  input  logic        in_frame_end,
  output logic        out_valid,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import hptm_pkg::*;

  logic        tone_mode_r;
  logic [16:0] gain_r;
  logic        take;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign take      = start & ~busy;

  // Hold configuration; saturate gain at one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_mode_r <= 1'b0;
      gain_r      <= ONE_Q16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TONE_MODE:     tone_mode_r <= cfg_data[0];
        CFG_EXPOSURE_GAIN: gain_r <= (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
        default: ;
      endcase
    end
  end

  // Advance valid bits and frame marks alongside the channel data
  logic vld_r [CH_LATENCY];
  logic fe_r  [CH_LATENCY];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH_LATENCY; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= take;
      for (int i = 1; i < CH_LATENCY; i++) vld_r[i] <= vld_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    fe_r[0] <= in_frame_end;
    for (int i = 1; i < CH_LATENCY; i++) fe_r[i] <= fe_r[i-1];
  end

  hptm_channel u_red (.clk(clk), .bits_i(in_red_in), .mode_i(tone_mode_r),
                      .gain_i(gain_r), .val_o(out_red_out));
  hptm_channel u_green (.clk(clk), .bits_i(in_green_in), .mode_i(tone_mode_r),
                        .gain_i(gain_r), .val_o(out_green_out));
  hptm_channel u_blue (.clk(clk), .bits_i(in_blue_in), .mode_i(tone_mode_r),
                       .gain_i(gain_r), .val_o(out_blue_out));

  assign out_valid         = vld_r[CH_LATENCY-1];
  assign out_frame_end_out = fe_r[CH_LATENCY-1];

endmodule

FILE: rtl/hptm_checker.sv
// Port-level checks for the tone mapper, bound to the top level.
module hptm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_frame_end,
  input logic out_valid,
  input logic out_frame_end_out,
  input logic cfg_ready
);
  import hptm_pkg::*;

  localparam int WW = $clog2(CH_LATENCY + 1);
  logic [WW-1:0] warm_r;
  logic          warm;

  // Count cycles out of reset, saturating at the latency
  always_ff @(posedge clk) begin
    if (!rst_n) warm_r <= '0;
    else if (warm_r != WW'(CH_LATENCY)) warm_r <= warm_r + 1'b1;
  end
  assign warm = (warm_r == WW'(CH_LATENCY));

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, CH_LATENCY)))
    else $error("result strobe does not match request latency");

  a_frame_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid) |-> (out_frame_end_out == $past(in_frame_end, CH_LATENCY)))
    else $error("frame-end mark out of step");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (!warm && out_valid) |-> $past(rst_n, 1))
    else $error("result strobe straight out of reset");

  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block refused a request out of reset");

endmodule

bind hdr_pixel_tone_mapper_top hptm_checker u_hptm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_frame_end(in_frame_end), .out_valid(out_valid),
  .out_frame_end_out(out_frame_end_out), .cfg_ready(cfg_ready)
);

FILE: verif/tb.sv
// Testbench for the HDR pixel tone mapper: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb;
  import hptm_pkg::*;

  localparam int N_RANDOM    = 500;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [30:0] red;
    logic [30:0] green;
    logic [30:0] blue;
    logic        frame_end;
    logic        has_exp;
    pixel_out_t  exp_out;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [30:0] in_red_in = '0;
  logic [30:0] in_green_in = '0;
  logic [30:0] in_blue_in = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_frame_end_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // predictor copy of the registers
  logic        mode_q;
  logic [16:0] gain_q;

  pixel_out_t  pending_pixels[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          idle_free = 1'b0;

  hdr_pixel_tone_mapper_top DUT (.*);

  always #5 clk = ~clk;

  // Convert a float bit pattern to Q16.16, truncating and saturating
  function automatic logic [31:0] float_to_q16(logic [30:0] bits);
    logic [7:0]  e;
    logic [63:0] sig;
    e = bits[30:23];
    sig = {40'd0, 1'b1, bits[22:0]};
    if (e == 8'd0) return 32'd0;
    if (e == 8'd255) return 32'hFFFF_FFFF;
    if (e >= 8'd134) begin
      if (e - 8'd134 > 8) return 32'hFFFF_FFFF;
      return 32'(sig << (e - 8'd134));
    end
    if (8'd134 - e >= 24) return 32'd0;
    return 32'(sig >> (8'd134 - e));
  endfunction

  // Map one channel to its display value under the current mode and gain
  function automatic logic [7:0] tone_channel(logic [30:0] bits);
    logic [63:0] x, t, num;
    logic [31:0] v;
    if (mode_q == 1'b0) begin
      x = {32'd0, float_to_q16(bits)};
      t = (x << 16) / (x + 64'd19661);
    end else begin
      num = 64'd1065307417 * 64'(65536 - 29789) + 64'(bits) * 64'd29789;
      t = {32'd0, float_to_q16(num[46:16])};
    end
    if (t > 64'd65536) t = 64'd65536;
    v = 32'((t * 64'd255) >> 16);
    return 8'((64'(v) * 64'(gain_q)) >> 16);
  endfunction

  function automatic pixel_out_t tone_pixel(logic [30:0] r, logic [30:0] g, logic [30:0] b,
                                            logic fe);
    return '{tone_channel(r), tone_channel(g), tone_channel(b), fe};
  endfunction

  function automatic logic [30:0] rand_pattern();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return {8'd255, 23'($urandom)};
      2: return {8'd0, 23'($urandom)};
      default: return {8'($urandom_range(100, 145)), 23'($urandom)};
    endcase
  endfunction

  // Timeout and cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    pixel_out_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_red_out, out_green_out, out_blue_out, out_frame_end_out};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%0d g%0d b%0d fe%0d, got r%0d g%0d b%0d fe%0d",
                     want.red, want.green, want.blue, want.frame_end,
                     got.red, got.green, got.blue, got.frame_end);
        end
      end
    end
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(logic [7:0] idx, logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TONE_MODE) mode_q = value[0];
    else if (idx == CFG_EXPOSURE_GAIN) gain_q = (value > ONE_Q16) ? ONE_Q16 : value;
  endtask

  // Drop start, drain outstanding results, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (CH_LATENCY + 4) @(posedge clk);
  endtask

  // Issue one pixel request, with random idle cycles before it
  task automatic send_pixel(logic [30:0] r, logic [30:0] g, logic [30:0] b, logic fe,
                            bit has_exp, pixel_out_t exp_out);
    pixel_out_t p;
    while (!idle_free && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_red_in    <= r;
    in_green_in  <= g;
    in_blue_in   <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (busy);
    p = tone_pixel(r, g, b, fe);
    if (has_exp && p !== exp_out) begin
      mismatches++;
      if (mismatches <= 10) $display("predictor disagrees with table: %h vs %h", p, exp_out);
    end
    pending_pixels.push_back(has_exp ? exp_out : p);
  endtask

  stim_row_t directed[$];

  initial begin
    pixel_out_t none;
    logic [16:0] gains[5];
    none = '0;
    mode_q = 1'b0;
    gain_q = 17'd65536;
    gains = '{17'd65536, 17'd0, 17'd32768, 17'h1FFFF, 17'd1};
    // mode 0 at reset: zero, subnormal, huge, infinity, one, all bits set
    directed.push_back('{31'd0, 31'h007F_FFFF, 31'h7F7F_FFFF, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd254, 1'b0}});
    directed.push_back('{31'h7F80_0000, 31'h7FFF_FFFF, 31'h3F80_0000, 1'b1, 1'b0, none});
    directed.push_back('{31'h4780_0000, 31'h477F_FFFF, 31'h3E99_999A, 1'b0, 1'b0, none});
    directed.push_back('{31'h0000_0001, 31'h3380_0000, 31'h4000_0000, 1'b1, 1'b0, none});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_pixel(directed[i].red, directed[i].green, directed[i].blue, directed[i].frame_end,
                 directed[i].has_exp, directed[i].exp_out);
    drain();

    // mode 1 gamma: infinity and huge values clamp to full scale
    write_reg(CFG_TONE_MODE, 17'd1);
    send_pixel(31'h7F80_0000, 31'h7F7F_FFFF, 31'd0, 1'b1, 1'b1, '{8'd255, 8'd255, 8'd0, 1'b1});
    send_pixel(31'h3F80_0000, 31'h3E80_0000, 31'h7FFF_FFFF, 1'b0, 1'b0, none);
    send_pixel(31'h0000_0001, 31'h3C00_0000, 31'h4100_0000, 1'b1, 1'b0, none);
    drain();
    // gain zero blanks everything; gain above one saturates
    write_reg(CFG_EXPOSURE_GAIN, 17'd0);
    send_pixel(31'h7F80_0000, 31'h3F80_0000, 31'h4000_0000, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0});
    drain();
    write_reg(CFG_EXPOSURE_GAIN, 17'h1FFFF);
    write_reg(8'd7, 17'd1);  // unknown index: ignored
    // exactly one lands just below one under the power curve
    send_pixel(31'h7F80_0000, 31'h3F80_0000, 31'd0, 1'b1, 1'b1, '{8'd255, 8'd254, 8'd0, 1'b1});
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_TONE_MODE, 17'($urandom));
      write_reg(CFG_EXPOSURE_GAIN, (ph < 5) ? gains[ph] : 17'($urandom_range(0, 70000)));
      idle_free = (ph == 6);
      for (int k = 0; k < N_RANDOM / 10; k++)
        send_pixel(rand_pattern(), rand_pattern(), rand_pattern(), 1'($urandom), 1'b0, none);
      idle_free = 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
